// ===== rtl/tga_pkg.sv =====
package tga_pkg;

    localparam int MAX_DIM = 1024;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_IDSKIP = 3'd2;
    localparam logic [2:0] PH_PKTHDR = 3'd3;
    localparam logic [2:0] PH_PIXEL  = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;
    localparam logic [2:0] PH_EMIT   = 3'd6;

    localparam logic [1:0] ST_PIXELS   = 2'd0;
    localparam logic [1:0] ST_BAD_TYPE = 2'd1;
    localparam logic [1:0] ST_BAD_FMT  = 2'd2;
    localparam logic [1:0] ST_TOO_BIG  = 2'd3;

    localparam logic       CFG_PACK_555    = 1'b0;
    localparam logic       CFG_DITHER_SEED = 1'b1;

    localparam logic [15:0] LFSR_MASK  = 16'hB400;
    localparam logic [15:0] SEED_RESET = 16'd44257;

    typedef struct packed {
        logic [15:0] pixel_a;
        logic [19:0] addr_a;
        logic [15:0] pixel_b;
        logic [19:0] addr_b;
        logic        has_b;
        logic        run_last;
        logic        image_done;
        logic [1:0]  status;
    } result_t;

    typedef struct packed {
        logic       restart;
        logic       hdr_byte;
        logic       hdr_final;
        logic       id_skip;
        logic       pkt_hdr;
        logic       pix_byte;
        logic       place;
        logic       slot_b;
    } dp_cmd_t;

    typedef struct packed {
        logic [4:0] header_count;
        logic       id_zero_next;
        logic       id_none;
        logic       is_rle;
        logic       fault;
        logic       empty;
        logic       pix_complete;
        logic       packet_is_run;
        logic       packet_one;
        logic       last_pixel;
    } dp_stat_t;

endpackage

// ===== rtl/tga_datapath.sv =====
module tga_datapath
    import tga_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        pack_555,
    input  logic [15:0] dither_seed,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output logic [15:0] pix_now,
    output logic [19:0] addr_now,
    output logic [1:0]  hdr_status
);

    logic [4:0]  header_count_reg;
    logic [7:0]  id_skip_left_reg;
    logic        is_rle_reg;
    logic        four_byte_pixels_reg;
    logic [15:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic [9:0]  column_pos_reg;
    logic [10:0] rows_left_reg;
    logic [19:0] row_base_reg;
    logic [7:0]  packet_left_reg;
    logic        packet_is_run_reg;
    logic [1:0]  channel_index_reg;
    logic [23:0] bgr_reg;
    logic [15:0] lfsr_reg;
    logic        type_bad_reg;
    logic        fmt_bad_reg;

    logic [15:0] l1, l2, l3;
    logic [23:0] bgr_now;
    logic [8:0]  rs, gs, bs;
    logic [7:0]  rd, gd, bd;
    logic        too_big;
    logic [10:0] col_inc;
    logic        row_end;
    logic [31:0] base_full;

    function automatic logic [15:0] lfsr_step(input logic [15:0] v);
        lfsr_step = (v >> 1) ^ (v[0] ? LFSR_MASK : 16'd0);
    endfunction

    always_comb
    begin
        l1 = lfsr_step(lfsr_reg);
        l2 = lfsr_step(l1);
        l3 = lfsr_step(l2);
        bgr_now = bgr_reg;
        if (cmd.pix_byte && channel_index_reg == 2'd2)
            bgr_now[23:16] = data_byte;
        rs = {1'b0, bgr_now[23:16]} + {7'd0, lfsr_reg[1:0]};
        gs = {1'b0, bgr_now[15:8]} + {7'd0, l1[1:0]};
        bs = {1'b0, bgr_now[7:0]} + {7'd0, l2[1:0]};
        rd = rs[8] ? 8'hFF : rs[7:0];
        gd = gs[8] ? 8'hFF : gs[7:0];
        bd = bs[8] ? 8'hFF : bs[7:0];
        if (pack_555)
            pix_now = {1'b0, rd[7:3], gd[7:3], bd[7:3]};
        else
            pix_now = {rd[7:3], gd[7:2], bd[7:3]};
        addr_now = row_base_reg + {10'd0, column_pos_reg};
        col_inc = {1'b0, column_pos_reg} + 11'd1;
        row_end = {5'd0, col_inc} >= image_width_reg;
        too_big = (image_width_reg > 16'(MAX_DIM)) || (image_height_reg > 16'(MAX_DIM));
        hdr_status = type_bad_reg ? ST_BAD_TYPE : fmt_bad_reg ? ST_BAD_FMT :
                     too_big ? ST_TOO_BIG : ST_PIXELS;
        base_full = (32'(image_height_reg) - 32'd1) * 32'(image_width_reg);
        stat.header_count  = header_count_reg;
        stat.id_zero_next  = id_skip_left_reg == 8'd1;
        stat.id_none       = id_skip_left_reg == 8'd0;
        stat.is_rle        = is_rle_reg;
        stat.fault         = hdr_status != ST_PIXELS;
        stat.empty         = image_width_reg == 16'd0 || image_height_reg == 16'd0;
        stat.pix_complete  = channel_index_reg == (four_byte_pixels_reg ? 2'd3 : 2'd2);
        stat.packet_is_run = packet_is_run_reg;
        stat.packet_one    = packet_left_reg <= 8'd1;
        stat.last_pixel    = row_end && rows_left_reg == 11'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg     <= '0;
            id_skip_left_reg     <= '0;
            is_rle_reg           <= 1'b0;
            four_byte_pixels_reg <= 1'b0;
            image_width_reg      <= '0;
            image_height_reg     <= '0;
            column_pos_reg       <= '0;
            rows_left_reg        <= '0;
            row_base_reg         <= '0;
            packet_left_reg      <= '0;
            packet_is_run_reg    <= 1'b0;
            channel_index_reg    <= '0;
            bgr_reg              <= '0;
            lfsr_reg             <= SEED_RESET;
            type_bad_reg         <= 1'b0;
            fmt_bad_reg          <= 1'b0;
        end
        else if (cmd.restart)
        begin
            header_count_reg     <= 5'd1;
            id_skip_left_reg     <= data_byte;
            is_rle_reg           <= 1'b0;
            four_byte_pixels_reg <= 1'b0;
            image_width_reg      <= '0;
            image_height_reg     <= '0;
            column_pos_reg       <= '0;
            rows_left_reg        <= '0;
            row_base_reg         <= '0;
            packet_left_reg      <= '0;
            packet_is_run_reg    <= 1'b0;
            channel_index_reg    <= '0;
            bgr_reg              <= '0;
            lfsr_reg             <= dither_seed;
            type_bad_reg         <= 1'b0;
            fmt_bad_reg          <= 1'b0;
        end
        else
        begin
            if (cmd.hdr_byte)
            begin
                header_count_reg <= header_count_reg + 5'd1;
                unique case (header_count_reg)
                    5'd1: if (data_byte != 8'd0) fmt_bad_reg <= 1'b1;
                    5'd2:
                    begin
                        if (data_byte == 8'd2) is_rle_reg <= 1'b0;
                        else if (data_byte == 8'd10) is_rle_reg <= 1'b1;
                        else type_bad_reg <= 1'b1;
                    end
                    5'd12: image_width_reg[7:0] <= data_byte;
                    5'd13: image_width_reg[15:8] <= data_byte;
                    5'd14: image_height_reg[7:0] <= data_byte;
                    5'd15: image_height_reg[15:8] <= data_byte;
                    5'd16:
                    begin
                        if (data_byte == 8'd24) four_byte_pixels_reg <= 1'b0;
                        else if (data_byte == 8'd32) four_byte_pixels_reg <= 1'b1;
                        else fmt_bad_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (cmd.hdr_final)
            begin
                column_pos_reg <= '0;
                rows_left_reg  <= image_height_reg[10:0];
                row_base_reg   <= base_full[19:0];
            end
            if (cmd.id_skip)
                id_skip_left_reg <= id_skip_left_reg - 8'd1;
            if (cmd.pkt_hdr)
            begin
                packet_left_reg   <= {1'b0, data_byte[6:0]} + 8'd1;
                packet_is_run_reg <= data_byte[7];
                channel_index_reg <= '0;
                bgr_reg           <= '0;
            end
            if (cmd.pix_byte)
            begin
                unique case (channel_index_reg)
                    2'd0: bgr_reg[7:0] <= data_byte;
                    2'd1: bgr_reg[15:8] <= data_byte;
                    2'd2: bgr_reg[23:16] <= data_byte;
                    default: ;
                endcase
                if (!stat.pix_complete)
                    channel_index_reg <= channel_index_reg + 2'd1;
                else
                    channel_index_reg <= '0;
            end
            if (cmd.place)
            begin
                lfsr_reg <= l3;
                if (packet_left_reg != 8'd0)
                    packet_left_reg <= packet_left_reg - 8'd1;
                if (row_end)
                begin
                    column_pos_reg <= '0;
                    rows_left_reg  <= rows_left_reg - 11'd1;
                    row_base_reg   <= row_base_reg - {4'd0, image_width_reg};
                end
                else
                    column_pos_reg <= col_inc[9:0];
            end
        end
    end

endmodule

// ===== rtl/tga_control.sv =====
module tga_control
    import tga_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        first_byte,
    output dp_cmd_t     cmd,
    input  dp_stat_t    stat,
    input  logic [15:0] pix_now,
    input  logic [19:0] addr_now,
    input  logic [1:0]  hdr_status,
    output logic        m_tvalid,
    input  logic        m_tready,
    output result_t     m_res
);

    logic [2:0]  phase_reg, phase_next;
    logic        slot_b_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic        take;
    logic        out_free;
    logic        place;
    logic        done_now;
    logic        multi;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = phase_reg != PH_EMIT && out_free;
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_res    = out_reg;

    always_comb
    begin
        cmd        = '0;
        phase_next = phase_reg;
        place      = 1'b0;
        multi      = 1'b0;
        if (take && first_byte)
        begin
            cmd.restart = 1'b1;
            phase_next  = PH_HEADER;
        end
        else if (take)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    cmd.hdr_byte = 1'b1;
                    if (stat.header_count == 5'd17)
                    begin
                        cmd.hdr_final = 1'b1;
                        if (stat.fault || stat.empty)
                            phase_next = PH_DONE;
                        else if (!stat.id_none)
                            phase_next = PH_IDSKIP;
                        else
                            phase_next = stat.is_rle ? PH_PKTHDR : PH_PIXEL;
                    end
                end
                PH_IDSKIP:
                begin
                    cmd.id_skip = 1'b1;
                    if (stat.id_zero_next)
                        phase_next = stat.is_rle ? PH_PKTHDR : PH_PIXEL;
                end
                PH_PKTHDR:
                begin
                    cmd.pkt_hdr = 1'b1;
                    phase_next  = PH_PIXEL;
                end
                PH_PIXEL:
                begin
                    cmd.pix_byte = 1'b1;
                    if (stat.pix_complete)
                    begin
                        place = 1'b1;
                        multi = stat.is_rle && stat.packet_is_run;
                        if (stat.last_pixel)
                            phase_next = PH_DONE;
                        else if (multi && !stat.packet_one)
                            phase_next = PH_EMIT;
                        else if (stat.is_rle && stat.packet_one)
                            phase_next = PH_PKTHDR;
                    end
                end
                default: ;
            endcase
        end
        else if (phase_reg == PH_EMIT && out_free)
        begin
            place = 1'b1;
            multi = 1'b1;
            if (stat.last_pixel)
                phase_next = PH_DONE;
            else if (stat.packet_one)
                phase_next = PH_PKTHDR;
        end
        cmd.place  = place;
        cmd.slot_b = slot_b_reg;
    end

    assign done_now = place && stat.last_pixel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            slot_b_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            if (take && first_byte)
                slot_b_reg <= 1'b0;
            if (take && !first_byte && phase_reg == PH_HEADER &&
                stat.header_count == 5'd17 && stat.fault)
            begin
                out_valid_reg <= 1'b1;
                out_reg <= '{16'd0, 20'd0, 16'd0, 20'd0, 1'b0, 1'b1, 1'b0,
                             hdr_status};
            end
            if (place)
            begin
                if (!slot_b_reg)
                begin
                    out_reg.pixel_a    <= pix_now;
                    out_reg.addr_a     <= addr_now;
                    out_reg.pixel_b    <= '0;
                    out_reg.addr_b     <= '0;
                    out_reg.has_b      <= 1'b0;
                    out_reg.status     <= ST_PIXELS;
                    out_reg.image_done <= done_now;
                    out_reg.run_last   <= 1'b1;
                    if (multi && !done_now && !stat.packet_one)
                        slot_b_reg <= 1'b1;
                    else
                        out_valid_reg <= 1'b1;
                end
                else
                begin
                    out_reg.pixel_b    <= pix_now;
                    out_reg.addr_b     <= addr_now;
                    out_reg.has_b      <= 1'b1;
                    out_reg.image_done <= done_now;
                    out_reg.run_last   <= done_now || stat.packet_one;
                    out_valid_reg      <= 1'b1;
                    slot_b_reg         <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== rtl/tga_rle_decode_dither_rgb16.sv =====
// TGA byte-stream decoder with dithered RGB565/RGB555 output. One file byte is
// taken per cycle while header, ID and pixel bytes are consumed; a raw pixel
// leaves one result on its last byte. A run packet stalls the input while its
// pixels are placed, one pixel per cycle while the output register is free,
// through the single dither and address unit; the first pixel is placed with
// the last pixel byte, and a run of n pixels leaves ceil(n/2) results. A
// result waiting in the output register holds the input until it is taken.
// Writes to pack_555 and dither_seed take effect for new pixels and at the
// next first byte respectively.
module tga_rle_decode_dither_rgb16
    import tga_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tuser,   // first_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // pixel_a, addr_a, pixel_b, addr_b, has_b, image_done, status, zero pad
    output logic [79:0]  m_tdata,
    output logic         m_tlast,   // run_last
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data
);

    logic        pack_555_reg;
    logic [15:0] dither_seed_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [15:0] pix_now;
    logic [19:0] addr_now;
    logic [1:0]  hdr_status;
    result_t     res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pack_555_reg    <= 1'b0;
            dither_seed_reg <= SEED_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_PACK_555)
                pack_555_reg <= cfg_data[0];
            else
                dither_seed_reg <= cfg_data;
        end
    end

    tga_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (s_tdata),
        .pack_555    (pack_555_reg),
        .dither_seed (dither_seed_reg),
        .cmd         (cmd),
        .stat        (stat),
        .pix_now     (pix_now),
        .addr_now    (addr_now),
        .hdr_status  (hdr_status)
    );

    tga_control u_ctl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .first_byte (s_tuser),
        .cmd        (cmd),
        .stat       (stat),
        .pix_now    (pix_now),
        .addr_now   (addr_now),
        .hdr_status (hdr_status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_res      (res)
    );

    assign m_tdata = {4'd0, res.status, res.image_done, res.has_b, res.addr_b,
                      res.pixel_b, res.addr_a, res.pixel_a};
    assign m_tlast = res.run_last;

endmodule

// ===== rtl/tga_checker.sv =====
module tga_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic        m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");

    a_fault_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[75:74] != 2'd0 |-> m_tlast && !m_tdata[72])
        else $error("fault result malformed");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[73] |-> m_tlast)
        else $error("image done not last");

    a_nob: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[72] |-> m_tdata[71:36] == 36'd0)
        else $error("pixel b not cleared");

    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while result waits");

endmodule

bind tga_rle_decode_dither_rgb16 tga_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import tga_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [79:0]  m_tdata;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_index;
    logic [15:0]  cfg_data;

    tga_rle_decode_dither_rgb16 u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    localparam int DRAIN_CYCLES = 300;
    localparam int STALL_LIMIT  = 5000;

    // decoder state mirrored for prediction
    logic        cfg_pack_555;
    logic [15:0] cfg_seed;
    logic [2:0]  phase;
    int unsigned hdr_cnt, id_left, width, height, col, rows_left, row_base;
    int unsigned pkt_left, ch_idx, bgr;
    bit          rle, four_bytes, pkt_run, type_bad, fmt_bad;
    logic [15:0] lfsr;

    result_t     pixel_q[$];
    int          errors = 0;
    int          n_bytes;
    int          n_results = 0;
    int          n_files;
    int          quiet = 0;
    bit          idle_en;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int unsigned dither_chan(input int unsigned v);
        int unsigned s;
        s = v + lfsr[1:0];
        lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_MASK) : (lfsr >> 1);
        return (s > 255) ? 255 : s;
    endfunction

    function automatic logic [15:0] pack_pixel();
        int unsigned r, g, b;
        r = dither_chan((bgr >> 16) & 8'hFF);
        g = dither_chan((bgr >> 8) & 8'hFF);
        b = dither_chan(bgr & 8'hFF);
        if (cfg_pack_555)
            return 16'(((r >> 3) << 10) | ((g >> 3) << 5) | (b >> 3));
        return 16'(((r >> 3) << 11) | ((g >> 2) << 5) | (b >> 3));
    endfunction

    function automatic bit place_pixel(ref logic [15:0] pix[$], ref logic [19:0] adr[$]);
        pix.push_back(pack_pixel());
        adr.push_back(20'(row_base + col));
        col++;
        if (col >= width)
        begin
            col = 0;
            rows_left--;
            if (rows_left == 0)
            begin
                phase = PH_DONE;
                return 1'b1;
            end
            row_base -= width;
        end
        return 1'b0;
    endfunction

    function automatic void clear_image();
        hdr_cnt = 0; id_left = 0; rle = 0; four_bytes = 0; width = 0; height = 0;
        col = 0; rows_left = 0; row_base = 0; pkt_left = 0; pkt_run = 0;
        ch_idx = 0; bgr = 0; type_bad = 0; fmt_bad = 0;
    endfunction

    function automatic void push_result(input logic [15:0] pa, input logic [19:0] aa,
                                        input logic [15:0] pb, input logic [19:0] ab,
                                        input bit hb, input bit last, input bit done,
                                        input logic [1:0] st);
        result_t r;
        r.pixel_a = pa; r.addr_a = aa; r.pixel_b = pb; r.addr_b = ab;
        r.has_b = hb; r.run_last = last; r.image_done = done; r.status = st;
        pixel_q.push_back(r);
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input bit first);
        logic [15:0] pix[$];
        logic [19:0] adr[$];
        logic [1:0]  st;
        bit          fin;
        bit          hb;
        int          i;
        fin = 0;
        if (first)
        begin
            clear_image();
            lfsr = cfg_seed;
            phase = PH_HEADER;
        end
        case (phase)
            PH_HEADER:
            begin
                case (hdr_cnt)
                    0: id_left = b;
                    1: if (b != 0) fmt_bad = 1;
                    2: if (b == 2) rle = 0; else if (b == 10) rle = 1; else type_bad = 1;
                    12: width = b;
                    13: width |= b << 8;
                    14: height = b;
                    15: height |= b << 8;
                    16: if (b == 24) four_bytes = 0; else if (b == 32) four_bytes = 1;
                        else fmt_bad = 1;
                    default: ;
                endcase
                hdr_cnt++;
                if (hdr_cnt < 18)
                    return;
                st = type_bad ? ST_BAD_TYPE : fmt_bad ? ST_BAD_FMT :
                     (width > MAX_DIM || height > MAX_DIM) ? ST_TOO_BIG : ST_PIXELS;
                if (st != ST_PIXELS)
                begin
                    phase = PH_DONE;
                    push_result(0, 0, 0, 0, 0, 1, 0, st);
                    return;
                end
                if (width == 0 || height == 0)
                begin
                    phase = PH_DONE;
                    return;
                end
                col = 0;
                rows_left = height;
                row_base = (height - 1) * width;
                if (id_left != 0)
                    phase = PH_IDSKIP;
                else
                    phase = rle ? PH_PKTHDR : PH_PIXEL;
                return;
            end
            PH_IDSKIP:
            begin
                id_left--;
                if (id_left == 0)
                    phase = rle ? PH_PKTHDR : PH_PIXEL;
                return;
            end
            PH_PKTHDR:
            begin
                pkt_left = (b & 8'h7F) + 1;
                pkt_run = b[7];
                ch_idx = 0;
                bgr = 0;
                phase = PH_PIXEL;
                return;
            end
            PH_PIXEL:
            begin
                if (ch_idx < 3)
                    bgr |= b << (8 * ch_idx);
                if (ch_idx < (four_bytes ? 3 : 2))
                begin
                    ch_idx++;
                    return;
                end
                ch_idx = 0;
                if (!rle)
                    fin = place_pixel(pix, adr);
                else if (pkt_run)
                begin
                    while (pkt_left > 0 && !fin)
                    begin
                        fin = place_pixel(pix, adr);
                        pkt_left--;
                    end
                    pkt_left = 0;
                end
                else
                begin
                    fin = place_pixel(pix, adr);
                    if (pkt_left > 0)
                        pkt_left--;
                end
                bgr = 0;
                if (!fin && rle && pkt_left == 0)
                    phase = PH_PKTHDR;
            end
            default: return;
        endcase
        for (i = 0; i < pix.size(); i += 2)
        begin
            hb = (i + 1) < pix.size();
            push_result(pix[i], adr[i], hb ? pix[i + 1] : 16'd0, hb ? adr[i + 1] : 20'd0,
                        hb, (i + 2) >= pix.size(), ((i + 2) >= pix.size()) && fin,
                        ST_PIXELS);
        end
    endfunction

    // drive one request; valid stays high across back-to-back requests unless idle_en inserts idle cycles
    task automatic send_byte(input logic [7:0] b, input bit first);
        @(negedge clk);
        while (idle_en && $urandom_range(99) < 21)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        do
            @(posedge clk);
        while (!s_tready);
        decode_byte(b, first);
        n_bytes++;
    endtask

    task automatic hold_input();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drain();
        hold_input();
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_PACK_555)
            cfg_pack_555 = val[0];
        else
            cfg_seed = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_header(input logic [7:0] id_len, input logic [7:0] cmap,
                               input logic [7:0] kind, input logic [15:0] w,
                               input logic [15:0] h, input logic [7:0] bpp);
        int i;
        send_byte(id_len, 1'b1);
        send_byte(cmap, 1'b0);
        send_byte(kind, 1'b0);
        for (i = 3; i < 12; i++)
            send_byte(8'($urandom), 1'b0);
        send_byte(w[7:0], 1'b0);
        send_byte(w[15:8], 1'b0);
        send_byte(h[7:0], 1'b0);
        send_byte(h[15:8], 1'b0);
        send_byte(bpp, 1'b0);
        send_byte(8'($urandom), 1'b0);
        for (i = 0; i < id_len; i++)
            send_byte(8'($urandom), 1'b0);
        n_files++;
    endtask

    task automatic send_pixel(input bit four, input logic [31:0] v);
        int i;
        for (i = 0; i < (four ? 4 : 3); i++)
            send_byte(v[8 * i +: 8], 1'b0);
    endtask

    always @(negedge clk)
        m_tready <= idle_en ? ($urandom_range(99) >= 21) : 1'b1;

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            result_t got;
            result_t want;
            got.pixel_a = m_tdata[15:0];
            got.addr_a = m_tdata[35:16];
            got.pixel_b = m_tdata[51:36];
            got.addr_b = m_tdata[71:52];
            got.has_b = m_tdata[72];
            got.image_done = m_tdata[73];
            got.status = m_tdata[75:74];
            got.run_last = m_tlast;
            n_results++;
            if (pixel_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result exp none got %h", $time, got);
            end
            else
            begin
                want = pixel_q.pop_front();
                if (got.pixel_a !== want.pixel_a)
                    $display("%0t pixel_a exp %h got %h", $time, want.pixel_a, got.pixel_a);
                if (got.addr_a !== want.addr_a)
                    $display("%0t addr_a exp %0d got %0d", $time, want.addr_a, got.addr_a);
                if (got.pixel_b !== want.pixel_b)
                    $display("%0t pixel_b exp %h got %h", $time, want.pixel_b, got.pixel_b);
                if (got.addr_b !== want.addr_b)
                    $display("%0t addr_b exp %0d got %0d", $time, want.addr_b, got.addr_b);
                if (got.has_b !== want.has_b)
                    $display("%0t has_b exp %b got %b", $time, want.has_b, got.has_b);
                if (got.run_last !== want.run_last)
                    $display("%0t run_last exp %b got %b", $time, want.run_last, got.run_last);
                if (got.image_done !== want.image_done)
                    $display("%0t image_done exp %b got %b", $time, want.image_done,
                             got.image_done);
                if (got.status !== want.status)
                    $display("%0t status exp %0d got %0d", $time, want.status, got.status);
                if (got !== want)
                    errors++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("timeout after %0d idle cycles", quiet);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_idle_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        wait_drain();
    endtask

    task automatic test_raw_image();
        send_header(8'd1, 8'd0, 8'd2, 16'd2, 16'd2, 8'd24);
        send_pixel(1'b0, 32'hFFFFFF);
        send_pixel(1'b0, 32'h000000);
        repeat (2) send_pixel(1'b0, $urandom);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);
        wait_drain();
    endtask

    task automatic test_rle_rows();
        send_header(8'd0, 8'd0, 8'd10, 16'd3, 16'd3, 8'd32);
        send_byte(8'h84, 1'b0);
        send_pixel(1'b1, 32'hFFFEFDFC);
        send_byte(8'h01, 1'b0);
        send_pixel(1'b1, $urandom);
        send_pixel(1'b1, $urandom);
        send_byte(8'h85, 1'b0);
        send_pixel(1'b1, $urandom);
        send_byte(8'h33, 1'b0);
        wait_drain();
    endtask

    task automatic test_header_faults();
        send_header(8'd0, 8'd0, 8'd3, 16'd2, 16'd2, 8'd24);
        send_byte(8'h11, 1'b0);
        send_header(8'd0, 8'd1, 8'd2, 16'd2, 16'd2, 8'd24);
        send_header(8'd0, 8'd0, 8'd2, 16'd1025, 16'd1, 8'd24);
        wait_drain();
    endtask

    task automatic test_empty_image();
        send_header(8'd0, 8'd0, 8'd2, 16'd0, 16'd4, 8'd24);
        send_pixel(1'b0, $urandom);
        wait_drain();
    endtask

    task automatic test_restart();
        send_header(8'd0, 8'd0, 8'd2, 16'd4, 16'd4, 8'd24);
        send_pixel(1'b0, $urandom);
        send_byte(8'h44, 1'b0);
        send_header(8'd1, 8'd0, 8'd2, 16'd1, 16'd1, 8'd32);
        send_pixel(1'b1, $urandom);
        wait_drain();
    endtask

    task automatic test_long_runs();
        send_header(8'd0, 8'd0, 8'd10, 16'd16, 16'd8, 8'd24);
        send_byte(8'hFF, 1'b0);
        send_pixel(1'b0, $urandom);
        wait_drain();
    endtask

    task automatic send_random_file();
        bit          four, is_rle;
        int unsigned w, h, left, cnt;
        is_rle = $urandom_range(1);
        four = $urandom_range(1);
        w = $urandom_range(6, 1);
        h = $urandom_range(4, 1);
        if ($urandom_range(9) == 0)
        begin
            // noise header, usually rejected
            send_header(8'($urandom_range(3)), 8'($urandom_range(1)), 8'($urandom),
                        16'($urandom), 16'($urandom), 8'($urandom));
            repeat ($urandom_range(4)) send_byte(8'($urandom), 1'b0);
            return;
        end
        send_header(8'($urandom_range(3)), 8'd0, is_rle ? 8'd10 : 8'd2, 16'(w), 16'(h),
                    four ? 8'd32 : 8'd24);
        left = w * h;
        if ($urandom_range(7) == 0)
            left = $urandom_range(left);
        while (left > 0)
        begin
            if (is_rle)
            begin
                cnt = $urandom_range((left > 8) ? 8 : left, 1);
                if ($urandom_range(9) == 0)
                    cnt = $urandom_range(128, 1);
                if ($urandom_range(1))
                begin
                    send_byte({1'b1, 7'(cnt - 1)}, 1'b0);
                    send_pixel(four, $urandom);
                end
                else
                begin
                    send_byte({1'b0, 7'(cnt - 1)}, 1'b0);
                    repeat ((cnt > left) ? left : cnt) send_pixel(four, $urandom);
                end
                left = (cnt > left) ? 0 : left - cnt;
            end
            else
            begin
                send_pixel(four, $urandom);
                left--;
            end
        end
        repeat ($urandom_range(2)) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic test_random_files(input int budget);
        int target;
        int paused;
        target = n_bytes + budget;
        paused = 0;
        while (n_bytes < target)
        begin
            send_random_file();
            if (!paused && n_bytes > target - budget / 2)
            begin
                wait_drain();
                paused = 1;
            end
        end
        wait_drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PACK_555;
        cfg_data = '0;
        idle_en = 1'b1;
        n_bytes = 0;
        n_files = 0;
        cfg_pack_555 = 1'b0;
        cfg_seed = SEED_RESET;
        phase = PH_IDLE;
        clear_image();
        lfsr = SEED_RESET;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_bytes();
        test_raw_image();
        test_rle_rows();
        test_header_faults();
        test_empty_image();
        test_restart();

        write_cfg(CFG_PACK_555, 16'd1);
        write_cfg(CFG_DITHER_SEED, 16'd0);
        idle_en = 1'b0;
        test_long_runs();

        idle_en = 1'b1;
        write_cfg(CFG_PACK_555, 16'd0);
        write_cfg(CFG_DITHER_SEED, 16'($urandom_range(65535, 1)));
        test_random_files(20);

        $display("covered %0d bytes in %0d files, %0d results checked", n_bytes, n_files,
                 n_results);
        $display("raw and RLE, 24/32 bpp, header faults, restarts, long runs, both packings");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
